[sv/fpa_pkg.sv]
// Shared codes and constants of the fixed block pool allocator.
package fpa_pkg;

    // Operation codes of the mode field
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ELEMENT_SIZE   = 2'd0;
    localparam logic [1:0] REG_ALIGNMENT_MASK = 2'd1;
    localparam logic [1:0] REG_ELEMENT_COUNT  = 2'd2;
    localparam logic [1:0] REG_BASE_ADDRESS   = 2'd3;

    // Pool layout
    localparam logic [8:0]  HEADER_BYTES      = 9'd16;
    localparam logic [15:0] MIN_ELEMENT_BYTES = 16'd4;
    localparam int          STRIDE_W          = 17;

    // Reset values of the configuration registers
    localparam logic [15:0] ELEMENT_SIZE_RST   = 16'd4;
    localparam logic [7:0]  ALIGNMENT_MASK_RST = 8'd3;

endpackage

[sv/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: free stack in RAM, fresh mark, address unit.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------------
//   s_      | in        | s_valid / s_ready | s_mode, s_element_index
//   m_      | out       | m_valid / m_ready | m_status, m_granted_index, m_granted_address,
//           |           |                   | m_free_left
//   cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// Each item passes S_IDLE, then S_EXEC: the accept in S_IDLE reads or writes the
// link RAM and multiplies index by stride; S_EXEC takes the link word from the RAM
// port, forms the address and loads the output register.
// A result waiting in the output register does not block the next accept;
// S_EXEC holds until the output register is free.
// Reset is synchronous, active low; the link RAM needs no clearing pass.
module fixed_block_pool_allocator
    import fpa_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [9:0]  s_element_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_granted_index,
    output logic [31:0] m_granted_address,
    output logic [10:0] m_free_left
);

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int PTR_W = $clog2(POOL_DEPTH + 1);
    localparam int MUL_W = IDX_W + STRIDE_W;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Configuration
    logic [15:0] element_size_reg;
    logic [7:0]  alignment_mask_reg;
    logic [10:0] element_count_reg;
    logic [31:0] base_address_reg;

    // Allocator state
    logic             state_reg;
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] fresh_mark_reg;
    logic [PTR_W-1:0] free_total_reg;

    // Per item
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       status_reg;
    logic             zero_addr_reg;
    logic             pop_reg;
    logic [31:0]      product_reg;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [9:0]  m_index_reg;
    logic [31:0] m_address_reg;
    logic [10:0] m_free_reg;

    logic [PTR_W-1:0] link_rd_data;

    logic                      accept;
    logic                      out_free;
    logic [PTR_W-1:0]          pool_cnt;
    logic [15:0]               elem_bytes;
    logic [STRIDE_W-1:0]       stride;
    logic [8:0]                header;
    logic                      is_alloc;
    logic                      is_free;
    logic                      do_pop;
    logic                      do_fresh;
    logic                      bad_index;
    logic [IDX_W-1:0]          idx_sel;
    logic [1:0]                status_sel;
    logic [IDX_W+STRIDE_W-1:0] mul_full;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign pool_cnt = (32'(element_count_reg) > 32'(POOL_DEPTH)) ? NULL_PTR
                                                                  : PTR_W'(element_count_reg);
    assign elem_bytes = (element_size_reg < MIN_ELEMENT_BYTES) ? MIN_ELEMENT_BYTES
                                                               : element_size_reg;
    assign stride = (STRIDE_W'(elem_bytes) + STRIDE_W'(alignment_mask_reg))
                    & ~STRIDE_W'(alignment_mask_reg);
    assign header = (HEADER_BYTES + 9'(alignment_mask_reg)) & ~9'(alignment_mask_reg);

    // Decode the item: take from the stack first, then from the fresh range
    assign is_alloc  = (s_mode == MODE_ALLOC);
    assign is_free   = (s_mode == MODE_FREE);
    assign do_pop    = is_alloc && (free_head_reg != NULL_PTR);
    assign do_fresh  = is_alloc && !do_pop && (fresh_mark_reg < pool_cnt);
    assign bad_index = is_free && (32'(s_element_index) >= 32'(pool_cnt));

    always_comb begin
        idx_sel    = '0;
        status_sel = STATUS_OK;
        priority if (do_pop) begin
            idx_sel = free_head_reg[IDX_W-1:0];
        end else if (do_fresh) begin
            idx_sel = fresh_mark_reg[IDX_W-1:0];
        end else if (is_alloc) begin
            status_sel = STATUS_EMPTY;
        end else if (bad_index) begin
            status_sel = STATUS_BAD_INDEX;
        end else if (is_free) begin
            idx_sel = IDX_W'(s_element_index);
        end else begin
            status_sel = STATUS_OK;
        end
    end

    assign mul_full = MUL_W'(idx_sel) * MUL_W'(stride);

    fpa_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (accept && is_free && !bad_index),
        .wr_addr (IDX_W'(s_element_index)),
        .wr_data (free_head_reg),
        .rd_en   (accept && do_pop),
        .rd_addr (free_head_reg[IDX_W-1:0]),
        .rd_data (link_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_size_reg   <= ELEMENT_SIZE_RST;
            alignment_mask_reg <= ALIGNMENT_MASK_RST;
            element_count_reg  <= '0;
            base_address_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ELEMENT_SIZE:   element_size_reg   <= cfg_wdata[15:0];
                REG_ALIGNMENT_MASK: alignment_mask_reg <= cfg_wdata[7:0];
                REG_ELEMENT_COUNT:  element_count_reg  <= cfg_wdata[10:0];
                REG_BASE_ADDRESS:   base_address_reg   <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_head_reg  <= NULL_PTR;
            fresh_mark_reg <= '0;
            free_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == S_EXEC && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                        if (s_mode == MODE_INIT) begin
                            free_head_reg  <= NULL_PTR;
                            fresh_mark_reg <= '0;
                            free_total_reg <= pool_cnt;
                        end else if (do_pop || do_fresh) begin
                            if (do_fresh) begin
                                fresh_mark_reg <= fresh_mark_reg + PTR_W'(1);
                            end
                            if (free_total_reg != '0) begin
                                free_total_reg <= free_total_reg - PTR_W'(1);
                            end
                        end else if (is_free && !bad_index) begin
                            free_head_reg <= PTR_W'(s_element_index);
                            if (free_total_reg != NULL_PTR) begin
                                free_total_reg <= free_total_reg + PTR_W'(1);
                            end
                        end
                    end
                end
                S_EXEC: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        state_reg <= S_IDLE;
                        if (pop_reg) begin
                            free_head_reg <= link_rd_data;
                        end
                    end
                end
            endcase
        end
    end

    // Per-item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg       <= idx_sel;
            status_reg    <= status_sel;
            zero_addr_reg <= !(do_pop || do_fresh || (is_free && !bad_index));
            pop_reg       <= do_pop;
            product_reg   <= 32'(mul_full);
        end
        if (state_reg == S_EXEC && out_free) begin
            m_status_reg  <= status_reg;
            m_index_reg   <= 10'(idx_reg);
            m_address_reg <= zero_addr_reg ? 32'd0
                                           : base_address_reg + 32'(header) + product_reg;
            m_free_reg    <= 11'(free_total_reg);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_index   = m_index_reg;
    assign m_granted_address = m_address_reg;
    assign m_free_left       = m_free_reg;

    // Every accepted item moves to S_EXEC
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter second cycle");

    // Leaving S_EXEC always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after second cycle");

    // A waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_address_reg)
                                       && $stable(m_free_reg)))
        else $error("waiting result overwritten");

    // Pointers and count stay within the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg <= NULL_PTR) && (fresh_mark_reg <= NULL_PTR)
        && (free_total_reg <= NULL_PTR))
        else $error("pool pointer or count out of range");

    // Fresh mark only advances on an allocate from the fresh range; only init resets it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fresh_mark_reg != $past(fresh_mark_reg) && $past(aresetn))
        |-> ($past(accept) && ($past(do_fresh) || $past(s_mode) == MODE_INIT)))
        else $error("fresh mark moved without an allocate or init");

endmodule

[sv/fpa_ram.sv]
// Generic simple dual-port RAM with registered read data.
module fpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[dv/fixed_block_pool_allocator_tb.sv]
// Self-checking testbench for the fixed block pool allocator.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
    import fpa_pkg::*;

    localparam int POOL_SLOTS  = 1024;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 600;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  index;
        logic [31:0] address;
        logic [10:0] free_left;
    } pool_grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_ELEMENT_SIZE;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_NOP;
    logic [9:0]  s_element_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [9:0]  m_granted_index;
    logic [31:0] m_granted_address;
    logic [10:0] m_free_left;

    // Shadow of the pool: free stack links, stack top, high-water mark, free count
    logic [10:0] link_mem [POOL_SLOTS];
    logic [10:0] stack_top = 11'(POOL_SLOTS);
    logic [10:0] fresh_next = '0;
    logic [10:0] free_cnt = '0;
    logic [15:0] cfg_elem_size = ELEMENT_SIZE_RST;
    logic [7:0]  cfg_align_mask = ALIGNMENT_MASK_RST;
    logic [10:0] cfg_elem_count = '0;
    logic [31:0] cfg_base = '0;

    pool_grant_t expected_grants [$];
    int          live_blocks [$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    fixed_block_pool_allocator #(.POOL_DEPTH(POOL_SLOTS)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_element_index   (s_element_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_index   (m_granted_index),
        .m_granted_address (m_granted_address),
        .m_free_left       (m_free_left)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] block_address(input logic [9:0] idx);
        logic [31:0] mask;
        logic [31:0] size;
        logic [31:0] header;
        logic [31:0] stride;
        mask   = {24'd0, cfg_align_mask};
        size   = (cfg_elem_size < MIN_ELEMENT_BYTES) ? 32'(MIN_ELEMENT_BYTES)
                                                     : {16'd0, cfg_elem_size};
        header = (32'(HEADER_BYTES) + mask) & ~mask;
        stride = (size + mask) & ~mask;
        return cfg_base + header + {22'd0, idx} * stride;
    endfunction

    // Work out the grant for one request and advance the shadow pool
    function automatic pool_grant_t predict_grant(input logic [1:0] mode,
                                                  input logic [9:0] req);
        pool_grant_t g;
        logic [10:0] usable;
        logic [10:0] idx;
        usable = (cfg_elem_count > 11'(POOL_SLOTS)) ? 11'(POOL_SLOTS) : cfg_elem_count;
        g = '0;
        case (mode)
            MODE_INIT: begin
                stack_top  = 11'(POOL_SLOTS);
                fresh_next = '0;
                free_cnt   = usable;
                live_blocks.delete();
            end
            MODE_ALLOC: begin
                if (stack_top < 11'(POOL_SLOTS) || fresh_next < usable) begin
                    if (stack_top < 11'(POOL_SLOTS)) begin
                        idx       = stack_top;
                        stack_top = link_mem[idx[9:0]];
                        if (stack_top > 11'(POOL_SLOTS))
                            stack_top = 11'(POOL_SLOTS);
                    end else begin
                        idx        = fresh_next;
                        fresh_next = fresh_next + 11'd1;
                    end
                    if (free_cnt > 0)
                        free_cnt = free_cnt - 11'd1;
                    g.index   = idx[9:0];
                    g.address = block_address(idx[9:0]);
                    live_blocks.push_back(int'(idx));
                end else begin
                    g.status = STATUS_EMPTY;
                end
            end
            MODE_FREE: begin
                if ({1'b0, req} >= usable) begin
                    g.status = STATUS_BAD_INDEX;
                end else begin
                    link_mem[req] = stack_top;
                    stack_top     = {1'b0, req};
                    if (free_cnt < 11'(POOL_SLOTS))
                        free_cnt = free_cnt + 11'd1;
                    g.index   = req;
                    g.address = block_address(req);
                end
            end
            default: ;
        endcase
        g.free_left = free_cnt;
        return g;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [9:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_element_index <= req;
        do @(posedge aclk); while (!s_ready);
        expected_grants.push_back(predict_grant(mode, req));
    endtask

    // Hold the sender until every grant is back, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure_pool(input logic [15:0] size, input logic [7:0] mask,
                                  input logic [10:0] count, input logic [31:0] base);
        logic [31:0] values [4];
        logic [1:0]  regs [4];
        values = '{{16'd0, size}, {24'd0, mask}, {21'd0, count}, base};
        regs   = '{REG_ELEMENT_SIZE, REG_ALIGNMENT_MASK, REG_ELEMENT_COUNT,
                   REG_BASE_ADDRESS};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= values[i];
            @(posedge aclk);
        end
        cfg_wr_en      <= 1'b0;
        cfg_elem_size  = size;
        cfg_align_mask = mask;
        cfg_elem_count = count;
        cfg_base       = base;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_grants
        pool_grant_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $error("grant with none outstanding: status %0d index %0d",
                       m_status, m_granted_index);
                mismatch_count++;
            end else begin
                want = expected_grants.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("granted_index", 32'(want.index), 32'(m_granted_index));
                check_field("granted_address", want.address, m_granted_address);
                check_field("free_left", 32'(want.free_left), 32'(m_free_left));
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Untouched registers after reset: nothing usable until the pool is set up
    task automatic test_reset_defaults();
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_FREE, 10'd0);
        send_item(MODE_NOP, 10'h3FF);
        send_item(MODE_INIT, 10'd0);
        wait_drained();
    endtask

    // Largest pool, widest alignment, address wrap, double free, count saturation
    task automatic test_full_pool();
        configure_pool(16'd0, 8'hFF, 11'd1024, 32'hFFFF_FF00);
        send_item(MODE_INIT, 10'h3FF);
        send_item(MODE_FREE, 10'd7);
        send_item(MODE_ALLOC, 10'h3FF);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_FREE, 10'h3FF);
        send_item(MODE_FREE, 10'd0);
        send_item(MODE_FREE, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        wait_drained();
        configure_pool(16'hFFFF, 8'd0, 11'h7FF, 32'd0);
        send_item(MODE_INIT, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_FREE, 10'h3FF);
        wait_drained();
    endtask

    // Tiny pool runs dry; shrinking it without init moves the bounds
    task automatic test_small_pool();
        configure_pool(16'd1, 8'd1, 11'd2, 32'h0000_1000);
        send_item(MODE_INIT, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_FREE, 10'd2);
        wait_drained();
        configure_pool(16'd6, 8'd7, 11'd1, 32'h0000_1000);
        send_item(MODE_FREE, 10'd1);
        send_item(MODE_ALLOC, 10'd0);
        send_item(MODE_FREE, 10'd0);
        send_item(MODE_ALLOC, 10'd0);
        wait_drained();
    endtask

    task automatic pick_random_layout();
        logic [15:0] size;
        logic [7:0]  mask;
        logic [10:0] count;
        int          r;
        r = $urandom_range(99);
        if (r < 40)      size = 16'($urandom_range(0, 16));
        else if (r < 80) size = 16'($urandom_range(17, 512));
        else if (r < 95) size = 16'($urandom_range(0, 65535));
        else             size = 16'hFFFF;
        if ($urandom_range(99) < 60) mask = 8'((1 << $urandom_range(0, 8)) - 1);
        else                         mask = 8'($urandom_range(0, 255));
        r = $urandom_range(99);
        if (r < 70)      count = 11'($urandom_range(1, 40));
        else if (r < 80) count = 11'($urandom_range(41, 1024));
        else if (r < 88) count = 11'd1024;
        else if (r < 94) count = 11'd0;
        else             count = 11'($urandom_range(1025, 2047));
        configure_pool(size, mask, count, $urandom);
    endtask

    // Mostly legal traffic: allocates, frees of held blocks, inits and no-ops, with stray and repeated frees mixed in
    task automatic issue_random_request(output bit counted);
        int          r;
        int          pick;
        logic [10:0] usable;
        logic [9:0]  req;
        usable  = (cfg_elem_count > 11'(POOL_SLOTS)) ? 11'(POOL_SLOTS) : cfg_elem_count;
        counted = 1'b1;
        r = $urandom_range(99);
        if (r < 48) begin
            send_item(MODE_ALLOC, 10'($urandom));
        end else if (r < 90) begin
            if (live_blocks.size() != 0 && $urandom_range(9) < 8) begin
                pick = $urandom_range(live_blocks.size() - 1);
                req  = 10'(live_blocks[pick]);
                live_blocks.delete(pick);
            end else if (usable != 0 && $urandom_range(1) == 0) begin
                req = 10'($urandom_range(int'(usable) - 1));
            end else begin
                req = 10'($urandom);
            end
            send_item(MODE_FREE, req);
        end else if (r < 95) begin
            send_item(MODE_INIT, 10'($urandom));
        end else begin
            send_item(MODE_NOP, 10'($urandom));
            counted = 1'b0;
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int  done;
        bit  counted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int layout = 0; layout < 3; layout++) begin
            wait_drained();
            pick_random_layout();
            if ($urandom_range(99) < 85)
                send_item(MODE_INIT, 10'($urandom));
            done = 0;
            while (done < PHASE_ITEMS / 3) begin
                issue_random_request(counted);
                if (counted)
                    done++;
                if (layout == 0 && done == PHASE_ITEMS / 6)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_full_pool();
        test_small_pool();
        test_random_traffic(13, 56);
        test_random_traffic(56, 13);
        test_random_traffic(0, 0);
        while (expected_grants.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
sv/fpa_pkg.sv
sv/fpa_ram.sv
sv/fixed_block_pool_allocator.sv
dv/fixed_block_pool_allocator_tb.sv
